>>> rtl/swlat_pkg.sv
// shared types and constants for the sliding window latency statistics block
// no dependencies

package swlat_pkg;

  localparam int unsigned SAMPLE_W = 64;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned COUNT_W  = 7;

  // q1.16 one and the rounding term for the ceiling in the rank computation
  localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'h1_0000;
  localparam logic [FRAC_W-1:0] FRAC_ROUND = 17'h0_ffff;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_REPORT = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RANK = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  typedef struct packed {
    func_e                func;
    logic [SAMPLE_W-1:0]  sample_ns;
    logic [FRAC_W-1:0]    percentile_fraction;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   sample_count;
    logic [SAMPLE_W-1:0]  last_ns;
    logic [SAMPLE_W-1:0]  min_ns;
    logic [SAMPLE_W-1:0]  max_ns;
    logic [SAMPLE_W-1:0]  total_ns;
    logic [SAMPLE_W-1:0]  percentile_ns;
  } rsp_t;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic record;   // shift the held samples one cell down, newest enters cell 0
    logic load;     // copy held sample into the circulating token
    logic rotate;   // tokens move one cell toward cell 0, wrapping at the end
    logic rank_en;  // tokens collect their rank while passing
  } cell_ctrl_t;

  // controls of the accumulator at the head of the chain
  typedef struct packed {
    logic clear;
    logic accum;
  } head_ctrl_t;

endpackage

>>> rtl/swlat_cell.sv
// one cell of the window chain: a held sample and a circulating rank token
// depends on swlat_pkg

module swlat_cell import swlat_pkg::*; #(
  parameter int unsigned WINDOW = 64,
  parameter int unsigned POS    = 0
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  cell_ctrl_t                                      ctrl_i,
  input  logic [$clog2(WINDOW+1)-1:0]                     count_i,
  input  logic [SAMPLE_W-1:0]                             shift_val_i,
  input  logic [SAMPLE_W-1:0]                             nxt_val_i,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]  nxt_rank_i,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]  nxt_idx_i,
  input  logic                                            nxt_tag_i,
  output logic [SAMPLE_W-1:0]                             hold_val_o,
  output logic [SAMPLE_W-1:0]                             tok_val_o,
  output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]  tok_rank_o,
  output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]  tok_idx_o,
  output logic                                            tok_tag_o
);

  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW+1);

  logic [SAMPLE_W-1:0] hold_q, hold_d;
  logic                hvld_q, hvld_d;
  logic [SAMPLE_W-1:0] val_q, val_d;
  logic [IW-1:0]       rank_q, rank_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic                tag_q, tag_d;
  logic                below;
  logic                mine;

  // the held sample orders before the token: smaller, or equal and newer position
  assign below = (hold_q < val_q) || ((hold_q == val_q) && (IW'(POS) < idx_q));
  assign mine  = CW'(POS) < count_i;

  always_comb begin
    hold_d = hold_q;
    hvld_d = hvld_q;
    val_d  = val_q;
    rank_d = rank_q;
    idx_d  = idx_q;
    tag_d  = tag_q;
    if (ctrl_i.record) begin
      hold_d = shift_val_i;
    end
    if (ctrl_i.load) begin
      hvld_d = mine;
      val_d  = hold_q;
      rank_d = '0;
      idx_d  = IW'(POS);
      tag_d  = mine;
    end else if (ctrl_i.rotate) begin
      val_d  = nxt_val_i;
      rank_d = nxt_rank_i;
      idx_d  = nxt_idx_i;
      tag_d  = nxt_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    val_q  <= val_d;
    rank_q <= rank_d;
    idx_q  <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvld_q <= 1'b0;
      tag_q  <= 1'b0;
    end else begin
      hvld_q <= hvld_d;
      tag_q  <= tag_d;
    end
  end

  assign hold_val_o = hold_q;
  assign tok_val_o  = val_q;
  assign tok_rank_o = rank_q + IW'(ctrl_i.rank_en && hvld_q && below);
  assign tok_idx_o  = idx_q;
  assign tok_tag_o  = tag_q;

endmodule

>>> rtl/swlat_head.sv
// accumulator at the head of the chain: sum, min, max and percentile pick
// depends on swlat_pkg

module swlat_head import swlat_pkg::*; #(
  parameter int unsigned WINDOW = 64
) (
  input  logic                                            clk_i,
  input  head_ctrl_t                                      ctrl_i,
  input  logic [SAMPLE_W-1:0]                             tok_val_i,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]  tok_rank_i,
  input  logic                                            tok_tag_i,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]  pidx_i,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0]  top_rank_i,
  output logic [SAMPLE_W-1:0]                             min_o,
  output logic [SAMPLE_W-1:0]                             max_o,
  output logic [SAMPLE_W-1:0]                             sum_o,
  output logic [SAMPLE_W-1:0]                             pct_o
);

  logic [SAMPLE_W-1:0] min_q, min_d;
  logic [SAMPLE_W-1:0] max_q, max_d;
  logic [SAMPLE_W-1:0] sum_q, sum_d;
  logic [SAMPLE_W-1:0] pct_q, pct_d;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    sum_d = sum_q;
    pct_d = pct_q;
    if (ctrl_i.clear) begin
      min_d = '0;
      max_d = '0;
      sum_d = '0;
      pct_d = '0;
    end else if (ctrl_i.accum && tok_tag_i) begin
      sum_d = sum_q + tok_val_i;
      if (tok_rank_i == '0) begin
        min_d = tok_val_i;
      end
      if (tok_rank_i == top_rank_i) begin
        max_d = tok_val_i;
      end
      if (tok_rank_i == pidx_i) begin
        pct_d = tok_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
    sum_q <= sum_d;
    pct_q <= pct_d;
  end

  assign min_o = min_q;
  assign max_o = max_q;
  assign sum_o = sum_q;
  assign pct_o = pct_q;

endmodule

>>> rtl/sliding_window_latency_stats_core.sv
// sliding window latency statistics: top level with control and the cell chain
// depends on swlat_pkg, swlat_cell and swlat_head
//
// usage: present an item on req_i and raise start_i; it is taken at a rising
// edge where start_i is high and busy_o is low. func selects record, report,
// clear; the unused code is taken and ignored.
// record and clear complete in the transfer cycle and never raise busy_o.
// samples sit in a chain of WINDOW cells ordered by age; a record shifts the
// chain by one cell and the oldest sample drops off the end once it is full.
// a report loads a rank token in every cell, rotates the tokens once around
// the chain (state ST_RANK) so each collects its rank in the sorted order,
// then rotates them again (state ST_SCAN) past the head accumulator that forms
// sum, min, max and the percentile pick. the result appears on rsp_o with
// rsp_valid_o high for exactly one cycle, in state ST_RESP after the scan;
// busy_o stays high until the strobe ends, so the length of a report is
// set by the two trips of the tokens around the chain.
// the receiver cannot stall: the result is gone after that cycle.
// reset empties the window, zeroes the last sample and returns to idle.

module sliding_window_latency_stats_core import swlat_pkg::*; #(
  parameter int unsigned WINDOW = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW+1);
  localparam int unsigned PW = FRAC_W + CW + 1;
  localparam int unsigned RW = PW - 16;

  state_e              state_q, state_d;
  logic [IW-1:0]       step_q, step_d;
  logic [CW-1:0]       count_q, count_d;
  logic [SAMPLE_W-1:0] last_q, last_d;
  logic [IW-1:0]       pidx_q, pidx_d;
  logic [IW-1:0]       top_q, top_d;

  logic                accept;
  logic                last_step;
  cell_ctrl_t          cell_ctrl;
  head_ctrl_t          head_ctrl;
  logic [FRAC_W-1:0]   frac;
  logic [PW-1:0]       prod;
  logic [RW-1:0]       rank;
  logic [RW-1:0]       pidx;

  logic [SAMPLE_W-1:0] hold_val [WINDOW];
  logic [SAMPLE_W-1:0] tok_val  [WINDOW];
  logic [IW-1:0]       tok_rank [WINDOW];
  logic [IW-1:0]       tok_idx  [WINDOW];
  logic                tok_tag  [WINDOW];

  logic [SAMPLE_W-1:0] min_ns, max_ns, sum_ns, pct_ns;

  assign busy_o    = (state_q != ST_IDLE);
  assign accept    = start_i && !busy_o;
  assign last_step = (step_q == IW'(WINDOW-1));

  // nearest rank: ceil(f*n / 2^16), then index = max(rank,1)-1 capped at n-1
  assign frac = (req_i.percentile_fraction > FRAC_ONE) ? FRAC_ONE : req_i.percentile_fraction;
  assign prod = PW'(frac) * PW'(count_q) + PW'(FRAC_ROUND);
  assign rank = prod[PW-1:16];

  always_comb begin
    pidx = (rank == '0) ? '0 : rank - RW'(1);
    if ((count_q != '0) && (pidx >= RW'(count_q))) begin
      pidx = RW'(count_q) - RW'(1);
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    count_d   = count_q;
    last_d    = last_q;
    pidx_d    = pidx_q;
    top_d     = top_q;
    cell_ctrl = '0;
    head_ctrl = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.func)
            FUNC_RECORD: begin
              cell_ctrl.record = 1'b1;
              last_d = req_i.sample_ns;
              if (count_q < CW'(WINDOW)) begin
                count_d = count_q + CW'(1);
              end
            end
            FUNC_REPORT: begin
              cell_ctrl.load  = 1'b1;
              head_ctrl.clear = 1'b1;
              pidx_d  = pidx[IW-1:0];
              top_d   = IW'(count_q - CW'(1));
              step_d  = '0;
              state_d = ST_RANK;
            end
            FUNC_CLEAR: begin
              count_d = '0;
              last_d  = '0;
            end
            FUNC_NONE: begin
            end
          endcase
        end
      end
      ST_RANK: begin
        cell_ctrl.rotate  = 1'b1;
        cell_ctrl.rank_en = 1'b1;
        step_d = step_q + IW'(1);
        if (last_step) begin
          step_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cell_ctrl.rotate = 1'b1;
        head_ctrl.accum  = 1'b1;
        step_d = step_q + IW'(1);
        if (last_step) begin
          step_d  = '0;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      count_q <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    top_q  <= top_d;
  end

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    localparam int unsigned NXT = (g == WINDOW - 1) ? 0 : g + 1;
    logic [SAMPLE_W-1:0] shift_val;

    if (g == 0) begin : g_first
      assign shift_val = req_i.sample_ns;
    end else begin : g_rest
      assign shift_val = hold_val[g-1];
    end

    swlat_cell #(
      .WINDOW (WINDOW),
      .POS    (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .count_i     (count_q),
      .shift_val_i (shift_val),
      .nxt_val_i   (tok_val[NXT]),
      .nxt_rank_i  (tok_rank[NXT]),
      .nxt_idx_i   (tok_idx[NXT]),
      .nxt_tag_i   (tok_tag[NXT]),
      .hold_val_o  (hold_val[g]),
      .tok_val_o   (tok_val[g]),
      .tok_rank_o  (tok_rank[g]),
      .tok_idx_o   (tok_idx[g]),
      .tok_tag_o   (tok_tag[g])
    );
  end

  swlat_head #(
    .WINDOW (WINDOW)
  ) u_head (
    .clk_i      (clk_i),
    .ctrl_i     (head_ctrl),
    .tok_val_i  (tok_val[0]),
    .tok_rank_i (tok_rank[0]),
    .tok_tag_i  (tok_tag[0]),
    .pidx_i     (pidx_q),
    .top_rank_i (top_q),
    .min_o      (min_ns),
    .max_o      (max_ns),
    .sum_o      (sum_ns),
    .pct_o      (pct_ns)
  );

  assign rsp_valid_o         = (state_q == ST_RESP);
  assign rsp_o.sample_count  = COUNT_W'(count_q);
  assign rsp_o.last_ns       = last_q;
  assign rsp_o.min_ns        = min_ns;
  assign rsp_o.max_ns        = max_ns;
  assign rsp_o.total_ns      = sum_ns;
  assign rsp_o.percentile_ns = pct_ns;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(WINDOW))
    else $error("fill count beyond window");

  a_rsp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.func == FUNC_REPORT)) |=> busy_o && !rsp_valid_o)
    else $error("report transfer did not start the scan");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.min_ns <= rsp_o.percentile_ns) &&
                    (rsp_o.percentile_ns <= rsp_o.max_ns))
    else $error("percentile outside min and max");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (count_q == '0)) |-> (rsp_o.total_ns == '0) && (rsp_o.max_ns == '0))
    else $error("empty window reported nonzero statistics");

endmodule

>>> verif/sliding_window_latency_stats_core_tb.sv
// self-checking testbench for sliding_window_latency_stats_core
// depends on swlat_pkg and the core; a scoreboard class predicts every report

module sliding_window_latency_stats_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swlat_pkg::*;

  localparam int unsigned WINDOW       = 64;
  localparam int unsigned RANDOM_ITEMS = 1425;
  localparam int unsigned PHASE_LEN    = 180;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;

  logic clk_i;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic rsp_valid_o;
  rsp_t rsp_o;

  sliding_window_latency_stats_core #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  class window_stats_board;
    logic [SAMPLE_W-1:0] held [WINDOW];
    int unsigned         held_count  = 0;
    int unsigned         replace_ptr = 0;
    logic [SAMPLE_W-1:0] newest      = '0;
    rsp_t                expected_reports [$];
    int unsigned         errors      = 0;

    function rsp_t predict_report(logic [FRAC_W-1:0] frac);
      logic [SAMPLE_W-1:0] ranked [WINDOW];
      logic [SAMPLE_W-1:0] pick;
      int unsigned         f, rank, pos, j;
      rsp_t                r;
      r = '0;
      r.sample_count = held_count[COUNT_W-1:0];
      r.last_ns      = newest;
      if (held_count != 0) begin
        for (int i = 0; i < held_count; i++) begin
          r.total_ns += held[i];
          ranked[i] = held[i];
        end
        for (int i = 1; i < held_count; i++) begin
          pick = ranked[i];
          j = i;
          while (j > 0 && ranked[j-1] > pick) begin
            ranked[j] = ranked[j-1];
            j--;
          end
          ranked[j] = pick;
        end
        // nearest rank: ceil(f * n), fractions above one saturate
        f    = (frac > FRAC_ONE) ? FRAC_ONE : frac;
        rank = (f * held_count + FRAC_ROUND) >> (FRAC_W - 1);
        pos  = (rank < 1) ? 0 : rank - 1;
        if (pos > held_count - 1) pos = held_count - 1;
        r.min_ns        = ranked[0];
        r.max_ns        = ranked[held_count-1];
        r.percentile_ns = ranked[pos];
      end
      return r;
    endfunction

    function void note_item(req_t item);
      case (item.func)
        FUNC_RECORD: begin
          newest = item.sample_ns;
          if (held_count < WINDOW) begin
            held[held_count] = item.sample_ns;
            held_count++;
          end else begin
            held[replace_ptr] = item.sample_ns;
            replace_ptr = (replace_ptr + 1) % WINDOW;
          end
        end
        FUNC_CLEAR: begin
          held_count  = 0;
          replace_ptr = 0;
          newest      = '0;
        end
        FUNC_REPORT: begin
          expected_reports.insert(expected_reports.size(),
                                  predict_report(item.percentile_fraction));
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [SAMPLE_W-1:0] want,
                                logic [SAMPLE_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(rsp_t got);
      rsp_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result with no report pending, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("sample_count", SAMPLE_W'(want.sample_count), SAMPLE_W'(got.sample_count));
      compare_field("last_ns", want.last_ns, got.last_ns);
      compare_field("min_ns", want.min_ns, got.min_ns);
      compare_field("max_ns", want.max_ns, got.max_ns);
      compare_field("total_ns", want.total_ns, got.total_ns);
      compare_field("percentile_ns", want.percentile_ns, got.percentile_ns);
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction
  endclass

  window_stats_board board;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // results are checked before the input of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o) board.check_report(rsp_o);
      if (start_i && !busy_o) board.note_item(req_i);
    end
  end

  function automatic req_t make_item(func_e f, logic [SAMPLE_W-1:0] s,
                                     logic [FRAC_W-1:0] p);
    req_t item;
    item.func                = f;
    item.sample_ns           = s;
    item.percentile_fraction = p;
    return item;
  endfunction

  function automatic req_t random_item();
    req_t        item;
    int unsigned pick;
    pick = $urandom_range(0, 999);
    case ($urandom_range(0, 3))
      0: item.sample_ns = {$urandom, $urandom};
      1: item.sample_ns = SAMPLE_W'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 2))
          0: item.sample_ns = '0;
          1: item.sample_ns = '1;
          default: item.sample_ns = {1'b1, {(SAMPLE_W-1){1'b0}}};
        endcase
      end
      default: item.sample_ns = SAMPLE_W'($urandom);
    endcase
    case ($urandom_range(0, 5))
      3: begin
        case ($urandom_range(0, 3))
          0: item.percentile_fraction = '0;
          1: item.percentile_fraction = FRAC_W'(1);
          2: item.percentile_fraction = FRAC_ONE - 1;
          default: item.percentile_fraction = FRAC_ONE;
        endcase
      end
      4: item.percentile_fraction = FRAC_W'($urandom_range(FRAC_ONE + 1, (1 << FRAC_W) - 1));
      5: item.percentile_fraction = FRAC_W'($urandom_range(0, (1 << FRAC_W) - 1));
      default: item.percentile_fraction = FRAC_W'($urandom_range(0, FRAC_ONE));
    endcase
    // clears are rare so the window fills and wraps between them
    if (pick < 30) item.func = FUNC_NONE;
    else if (pick < 35) item.func = FUNC_CLEAR;
    else if (pick < 620) item.func = FUNC_RECORD;
    else item.func = FUNC_REPORT;
    return item;
  endfunction

  // holds start high until the transfer edge
  task automatic send_item(req_t item);
    start_i <= 1'b1;
    req_i   <= item;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_gap(int unsigned pct);
    while ($urandom_range(0, 99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0 || busy_o);
  endtask

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sliding_window_latency_stats_core_tb: done, errors");
    $finish;
  end

  initial begin
    req_t        item;
    int unsigned items_sent;
    int unsigned phase, cur_phase;
    int unsigned idle_pct;
    int unsigned idle_plan [4];
    board        = new;
    idle_plan    = '{0, 85, 0, 14};
    items_sent   = 0;
    cur_phase    = '1;
    idle_pct     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty window, then extremes of sample and fraction
    send_item(make_item(FUNC_REPORT, '0, '0));
    send_item(make_item(FUNC_REPORT, '1, FRAC_ONE));
    send_item(make_item(FUNC_RECORD, '0, '1));
    send_item(make_item(FUNC_REPORT, '0, FRAC_ONE));
    send_item(make_item(FUNC_RECORD, '1, '0));
    send_item(make_item(FUNC_REPORT, '0, '0));
    send_item(make_item(FUNC_REPORT, '0, FRAC_W'(1)));
    send_item(make_item(FUNC_REPORT, '0, FRAC_W'(32768)));
    send_item(make_item(FUNC_REPORT, '0, FRAC_ONE - 1));
    send_item(make_item(FUNC_REPORT, '0, '1));
    // second all-ones sample wraps the total
    send_item(make_item(FUNC_RECORD, '1, '0));
    send_item(make_item(FUNC_REPORT, '0, FRAC_ONE));
    send_item(make_item(FUNC_NONE, '1, '1));
    send_item(make_item(FUNC_REPORT, '0, FRAC_W'(32768)));
    send_item(make_item(FUNC_CLEAR, '1, '1));
    send_item(make_item(FUNC_REPORT, '0, FRAC_ONE));
    send_item(make_item(FUNC_RECORD, 64'h8000_0000_0000_0001, '0));
    send_item(make_item(FUNC_RECORD, 64'd5, '0));
    send_item(make_item(FUNC_RECORD, 64'd5, '0));
    send_item(make_item(FUNC_REPORT, '0, FRAC_W'(43691)));
    send_item(make_item(FUNC_REPORT, '0, FRAC_W'(21845)));
    send_item(make_item(FUNC_NONE, '0, '0));
    send_item(make_item(FUNC_REPORT, '0, '0));
    wait_drained();

    while (items_sent < RANDOM_ITEMS) begin
      phase = items_sent / PHASE_LEN;
      if (phase != cur_phase) begin
        // sender holds off at each phase change until all reports are back
        wait_drained();
        cur_phase = phase;
        idle_pct  = idle_plan[phase % 4];
      end
      item = random_item();
      send_item(item);
      if (item.func != FUNC_NONE) items_sent++;
      idle_gap(idle_pct);
    end

    wait_drained();
    repeat (2 * WINDOW + 4) @(posedge clk_i);
    if (board.pending() != 0) begin
      $display("%0t: reports left over, expected 0, actual %0d", $time, board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("sliding_window_latency_stats_core_tb: done, clean");
    end else begin
      $display("sliding_window_latency_stats_core_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/swlat_pkg.sv
rtl/swlat_cell.sv
rtl/swlat_head.sv
rtl/sliding_window_latency_stats_core.sv
verif/sliding_window_latency_stats_core_tb.sv
